// File: hdl/afpsm_pkg.sv
// Shared types, codes and constants for the audio frame peak and stuck monitor.
`default_nettype none

package afpsm_pkg;

	localparam int SampleW   = 16;
	localparam int PeakW     = 15;
	localparam int LevelW    = 8;
	localparam int FrameNumW = 32;
	localparam int VerdictW  = 2;
	localparam int RfLimitW  = 8;
	localparam int CfLimitW  = 16;
	localparam int CfgDataW  = 16;
	localparam int CfgIdxW   = 1;
	localparam int LevelShift = 7;

	// Output word: restart, frame_number, peak, level, packed from bit 0 up.
	localparam int OutDataW = 1 + FrameNumW + PeakW + LevelW;

	localparam logic [RfLimitW-1:0] RfLimitReset = RfLimitW'(3);
	localparam logic [CfLimitW-1:0] CfLimitReset = CfLimitW'(8);

	localparam logic [PeakW-1:0]   PeakMax  = {PeakW{1'b1}};
	localparam logic [SampleW-1:0] MostNeg  = {1'b1, {(SampleW-1){1'b0}}};

	typedef logic [VerdictW-1:0] verdict_t;
	localparam verdict_t VerdictAccepted = 2'd0;
	localparam verdict_t VerdictConstant = 2'd1;
	localparam verdict_t VerdictReadFail = 2'd2;

	typedef logic [CfgIdxW-1:0] cfg_idx_t;
	localparam cfg_idx_t CfgReadFailLimit     = 1'd0;
	localparam cfg_idx_t CfgConstantFrameLimit = 1'd1;

	// Magnitude of a signed sample, most negative value saturated.
	function automatic logic [PeakW-1:0] magnitude(input logic [SampleW-1:0] raw);
		logic [SampleW-1:0] neg;
		begin
			neg = (~raw) + SampleW'(1);
			if (!raw[SampleW-1])
				magnitude = raw[PeakW-1:0];
			else if (raw == MostNeg)
				magnitude = PeakMax;
			else
				magnitude = neg[PeakW-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: hdl/audio_frame_peak_and_stuck_monitor_core.sv
// Top level of the audio frame peak and stuck monitor.
// Usage:
//   Input stream (s_axis_*): one word per microphone sample. tdata is the
//   signed 16-bit sample, tlast marks the final sample of a frame, tuser set
//   means a read error (sample and tlast ignored, partial frame dropped).
//   Output stream (m_axis_*): one word per completed frame or read error.
//   tuser carries the verdict (accepted, constant, read failed); tdata packs
//   restart, frame_number, peak and level. Samples inside a frame give no word.
//   Config port: cfg_we/cfg_index/cfg_data write the read-fail limit (index 0)
//   and the constant-frame limit (index 1); write only while the block is idle.
// Timing:
//   A word accepted from s_axis sits in the input register; its result
//   is then loaded into the output register, which drives m_axis_tvalid.
//   Throughput is one word per cycle unless the output stalls; the per-frame
//   state update (compare, max, counters) fits between the two registers.
// Reset (arst_n low): both stages empty, frame state cleared, counters and
//   frame number zero, limits back to 3 and 8.
// Stall: with m_axis_tready low the result is held; the input register keeps
//   taking words that close no frame, and s_axis_tready drops once it holds a
//   word that must produce a result while the output register is still full.
`default_nettype none

module audio_frame_peak_and_stuck_monitor_core (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [afpsm_pkg::SampleW-1:0]         s_axis_tdata,  // [15:0] sample
	input  wire logic                                  s_axis_tlast,  // last_in_frame
	input  wire logic                                  s_axis_tuser,  // [0] read_error

	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// [0] restart, [32:1] frame_number, [47:33] peak, [55:48] level
	output logic [afpsm_pkg::OutDataW-1:0]             m_axis_tdata,
	output logic [afpsm_pkg::VerdictW-1:0]             m_axis_tuser,  // [1:0] verdict

	input  wire logic                                  cfg_we,
	input  wire logic [afpsm_pkg::CfgIdxW-1:0]         cfg_index,
	input  wire logic [afpsm_pkg::CfgDataW-1:0]        cfg_data
);

	// Input stage
	logic                              valid_s1;
	logic [afpsm_pkg::SampleW-1:0]     sample_s1;
	logic                              last_s1;
	logic                              err_s1;

	// Configuration
	logic [afpsm_pkg::RfLimitW-1:0]    rf_limit_q;
	logic [afpsm_pkg::CfLimitW-1:0]    cf_limit_q;

	// Frame and run state
	logic [afpsm_pkg::PeakW-1:0]       peak_q;
	logic [afpsm_pkg::SampleW-1:0]     first_q;
	logic                              all_eq_q;
	logic                              started_q;
	logic [afpsm_pkg::RfLimitW-1:0]    rf_cnt_q;
	logic [afpsm_pkg::CfLimitW-1:0]    cf_cnt_q;
	logic [afpsm_pkg::FrameNumW-1:0]   frame_num_q;

	// Next-state logic
	logic [afpsm_pkg::PeakW-1:0]       mag;
	logic [afpsm_pkg::PeakW-1:0]       peak_new;
	logic                              all_eq_new;
	logic [afpsm_pkg::RfLimitW-1:0]    rf_inc;
	logic [afpsm_pkg::CfLimitW-1:0]    cf_inc;
	logic                              rf_hit;
	logic                              cf_hit;
	logic                              has_result;
	logic                              out_free;
	logic                              consume;
	logic                              restart;
	afpsm_pkg::verdict_t               verdict;

	assign mag        = afpsm_pkg::magnitude(sample_s1);
	assign peak_new   = (!started_q || mag > peak_q) ? mag : peak_q;
	assign all_eq_new = !started_q || (all_eq_q && sample_s1 == first_q);
	assign rf_inc     = rf_cnt_q + afpsm_pkg::RfLimitW'(1);
	assign cf_inc     = cf_cnt_q + afpsm_pkg::CfLimitW'(1);
	assign rf_hit     = rf_inc >= rf_limit_q;
	assign cf_hit     = cf_inc >= cf_limit_q;

	assign has_result = err_s1 || last_s1;
	assign out_free   = !m_axis_tvalid || m_axis_tready;
	assign consume    = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || consume;

	always_comb begin
		if (err_s1) begin
			verdict = afpsm_pkg::VerdictReadFail;
			restart = rf_hit;
		end else if (all_eq_new) begin
			verdict = afpsm_pkg::VerdictConstant;
			restart = cf_hit;
		end else begin
			verdict = afpsm_pkg::VerdictAccepted;
			restart = 1'b0;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata;
			last_s1   <= s_axis_tlast;
			err_s1    <= s_axis_tuser;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_limit_q <= afpsm_pkg::RfLimitReset;
			cf_limit_q <= afpsm_pkg::CfLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				afpsm_pkg::CfgReadFailLimit:
					rf_limit_q <= cfg_data[afpsm_pkg::RfLimitW-1:0];
				afpsm_pkg::CfgConstantFrameLimit:
					cf_limit_q <= cfg_data[afpsm_pkg::CfLimitW-1:0];
				default: ;
			endcase
		end
	end

	// Frame and run state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			first_q     <= '0;
			all_eq_q    <= 1'b1;
			started_q   <= 1'b0;
			rf_cnt_q    <= '0;
			cf_cnt_q    <= '0;
			frame_num_q <= '0;
		end else if (consume) begin
			if (err_s1 || last_s1) begin
				// frame over either way: drop or close it
				peak_q    <= '0;
				first_q   <= '0;
				all_eq_q  <= 1'b1;
				started_q <= 1'b0;
			end else begin
				peak_q    <= peak_new;
				all_eq_q  <= all_eq_new;
				started_q <= 1'b1;
				if (!started_q)
					first_q <= sample_s1;
			end

			if (err_s1) begin
				rf_cnt_q <= rf_hit ? '0 : rf_inc;
			end else if (last_s1) begin
				rf_cnt_q    <= '0;
				frame_num_q <= frame_num_q + afpsm_pkg::FrameNumW'(1);
				if (all_eq_new)
					cf_cnt_q <= cf_hit ? '0 : cf_inc;
				else
					cf_cnt_q <= '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= consume && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && has_result) begin
			m_axis_tuser <= verdict;
			if (err_s1)
				m_axis_tdata <= {{(afpsm_pkg::OutDataW-1){1'b0}}, restart};
			else
				m_axis_tdata <= {peak_new[afpsm_pkg::PeakW-1:afpsm_pkg::LevelShift],
					peak_new, frame_num_q, restart};
		end
	end

endmodule

`default_nettype wire
